// File: rtl/core/sfcs_pkg.sv
// Shared types and constants of the SPI flash command sequencer.
`timescale 1ns / 1ps

package sfcs_pkg;

	// Stream widths
	localparam int IN_W  = 56;
	localparam int OUT_W = 48;

	// Request / item kinds carried in s_tuser
	localparam logic [2:0] FN_READ  = 3'd0;
	localparam logic [2:0] FN_PROG  = 3'd1;
	localparam logic [2:0] FN_SE    = 3'd2;
	localparam logic [2:0] FN_BE    = 3'd3;
	localparam logic [2:0] FN_ID    = 3'd4;
	localparam logic [2:0] FN_HOST  = 3'd5;
	localparam logic [2:0] FN_RX    = 3'd6;

	// Flash opcodes
	localparam logic [7:0] OP_PROGRAM = 8'h02;
	localparam logic [7:0] OP_WREN    = 8'h06;
	localparam logic [7:0] OP_READ    = 8'h03;
	localparam logic [7:0] OP_RDSR    = 8'h05;
	localparam logic [7:0] OP_RDID    = 8'h9F;
	localparam logic [7:0] OP_SE      = 8'h20;
	localparam logic [7:0] OP_BE      = 8'hC7;
	localparam logic [7:0] DUMMY      = 8'hA5;
	localparam int         WIP_BIT    = 0;

	localparam logic [23:0] ADDR_TOP = 24'hFFFFFF;

	typedef enum logic [9:0] {
		PH_IDLE  = 10'b00_0000_0001,
		PH_WREN  = 10'b00_0000_0010,
		PH_CMD   = 10'b00_0000_0100,
		PH_ADDR  = 10'b00_0000_1000,
		PH_RDATA = 10'b00_0001_0000,
		PH_HOST  = 10'b00_0010_0000,
		PH_PDATA = 10'b00_0100_0000,
		PH_RDSR  = 10'b00_1000_0000,
		PH_POLL  = 10'b01_0000_0000,
		PH_ID    = 10'b10_0000_0000
	} phase_t;

	// Result word, packed MSB first so spi_valid lands in bit 0
	typedef struct packed {
		logic        error;
		logic        done_res;
		logic [23:0] id_value;
		logic        id_valid;
		logic        want_data;
		logic [7:0]  read_byte;
		logic        read_valid;
		logic        cs_release_after;
		logic        cs_release_before;
		logic [7:0]  spi_byte;
		logic        spi_valid;
	} res_t;

endpackage

// File: rtl/core/sfcs_page_mod.sv
// Pipelined address-modulo-page unit (reciprocal multiply with one correction).
`timescale 1ns / 1ps

module sfcs_page_mod #(
	parameter int PAGE_BYTES = 256,
	localparam int PW = $clog2(PAGE_BYTES)
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [23:0]   addr,
	output logic          rem_valid,
	output logic [PW-1:0] rem
);

	localparam int SH  = 36;
	localparam int RW  = 37 - $clog2(PAGE_BYTES);
	localparam int QW  = RW - 12;
	localparam int MW  = 24 + RW;
	localparam int P2W = QW + 13;
	localparam logic [RW-1:0] RECIP = RW'((64'd1 << SH) / PAGE_BYTES);

	logic           v_s1, v_s2;
	logic [MW-1:0]  p1_s1;
	logic [P2W-1:0] p2_s2;
	logic [23:0]    addr_s1, addr_s2;
	logic [24:0]    rem_est;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1      <= 1'b0;
			v_s2      <= 1'b0;
			rem_valid <= 1'b0;
		end else begin
			v_s1      <= start;
			v_s2      <= v_s1;
			rem_valid <= v_s2;
		end
	end

	// quotient estimate is exact or one low
	assign rem_est = {1'b0, addr_s2} - 25'(p2_s2);

	always_ff @(posedge clk) begin
		p1_s1   <= MW'(addr) * MW'(RECIP);
		addr_s1 <= addr;
		p2_s2   <= P2W'(p1_s1[MW-1:SH]) * P2W'(PAGE_BYTES);
		addr_s2 <= addr_s1;
		if (rem_est >= 25'(PAGE_BYTES)) begin
			rem <= PW'(rem_est - 25'(PAGE_BYTES));
		end else begin
			rem <= PW'(rem_est);
		end
	end

endmodule

// File: rtl/core/spi_flash_command_sequencer_top.sv
// Top level of the SPI flash command sequencer: input register, sequencer, result register.
`timescale 1ns / 1ps
// A word accepted into the input register reaches the result register on m_tdata.
// Throughput: one word per cycle while the result is not stalled; the sequencer step sits
// between the input and result registers, and a stalled result stops the input register
// once it holds a word. The page-offset unit has its result well before the first data byte.
// Reset: arst_n clears the sequencer to idle and empties both registers.

module spi_flash_command_sequencer_top #(
	parameter int PAGE_BYTES = 256
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     s_tvalid,
	output logic                     s_tready,
	// address[23:0], length[39:24], host_byte[47:40], spi_rx_byte[55:48]
	input  logic [sfcs_pkg::IN_W-1:0] s_tdata,
	// func[2:0]
	input  logic [2:0]               s_tuser,
	output logic                     m_tvalid,
	input  logic                     m_tready,
	// spi_valid[0], spi_byte[8:1], cs_release_before[9], cs_release_after[10],
	// read_valid[11], read_byte[19:12], want_data[20], id_valid[21],
	// id_value[45:22], done_res[46], error[47]
	output logic [sfcs_pkg::OUT_W-1:0] m_tdata
);

	localparam int PW = $clog2(PAGE_BYTES);

	// input register
	logic        valid_s1;
	logic [2:0]  func_s1;
	logic [23:0] addr_s1;
	logic [15:0] len_s1;
	logic [7:0]  hb_s1;
	logic [7:0]  rx_s1;
	logic        advance;

	// result register
	logic           out_valid_q;
	sfcs_pkg::res_t out_q;

	// sequencer state
	sfcs_pkg::phase_t phase_q, phase_d;
	logic [2:0]       op_q, op_d;
	logic [23:0]      addr_q, addr_d;
	logic [15:0]      left_q, left_d;
	logic [1:0]       idx_q, idx_d;
	logic [15:0]      id_q, id_d;
	logic [PW-1:0]    rem_q, rem_d;
	sfcs_pkg::res_t   res;
	logic             chunk_end;
	logic [15:0]      left_dec;
	logic             mod_start;
	logic             mod_valid;
	logic [PW-1:0]    mod_rem;

	assign advance  = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !valid_s1 || advance;
	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (s_tready) begin
				valid_s1 <= s_tvalid;
			end
			if (advance) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			func_s1 <= s_tuser;
			addr_s1 <= s_tdata[23:0];
			len_s1  <= s_tdata[39:24];
			hb_s1   <= s_tdata[47:40];
			rx_s1   <= s_tdata[55:48];
		end
		if (advance) begin
			out_q <= res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= sfcs_pkg::PH_IDLE;
			op_q    <= '0;
			addr_q  <= '0;
			left_q  <= '0;
			idx_q   <= '0;
			id_q    <= '0;
			rem_q   <= '0;
		end else begin
			phase_q <= phase_d;
			op_q    <= op_d;
			addr_q  <= addr_d;
			left_q  <= left_d;
			idx_q   <= idx_d;
			id_q    <= id_d;
			rem_q   <= rem_d;
		end
	end

	// the next write address starts a page, or the word limit is reached
	assign chunk_end = (left_q <= 16'd1) || (rem_q == PW'(PAGE_BYTES - 1))
		|| (addr_q == sfcs_pkg::ADDR_TOP);
	assign left_dec  = left_q - 16'd1;
	assign mod_start = advance && (phase_q == sfcs_pkg::PH_IDLE) && (func_s1 == sfcs_pkg::FN_PROG);

	sfcs_page_mod #(
		.PAGE_BYTES(PAGE_BYTES)
	) u_page_mod (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (mod_start),
		.addr     (addr_s1),
		.rem_valid(mod_valid),
		.rem      (mod_rem)
	);

	always_comb begin
		res     = '0;
		phase_d = phase_q;
		op_d    = op_q;
		addr_d  = addr_q;
		left_d  = left_q;
		idx_d   = idx_q;
		id_d    = id_q;
		rem_d   = mod_valid ? mod_rem : rem_q;
		if (advance) begin
			unique case (func_s1) inside
				sfcs_pkg::FN_READ, sfcs_pkg::FN_PROG, sfcs_pkg::FN_SE,
				sfcs_pkg::FN_BE, sfcs_pkg::FN_ID: begin
					if (phase_q == sfcs_pkg::PH_IDLE) begin
						op_d   = func_s1;
						addr_d = addr_s1;
						left_d = len_s1;
						idx_d  = '0;
						if (func_s1 == sfcs_pkg::FN_READ) begin
							res.spi_valid = 1'b1;
							res.spi_byte  = sfcs_pkg::OP_READ;
							phase_d       = sfcs_pkg::PH_CMD;
						end else if (func_s1 == sfcs_pkg::FN_ID) begin
							id_d          = '0;
							res.spi_valid = 1'b1;
							res.spi_byte  = sfcs_pkg::OP_RDID;
							phase_d       = sfcs_pkg::PH_CMD;
						end else if (func_s1 == sfcs_pkg::FN_PROG && len_s1 == 16'd0) begin
							res.done_res = 1'b1;
						end else begin
							res.spi_valid        = 1'b1;
							res.spi_byte         = sfcs_pkg::OP_WREN;
							res.cs_release_after = 1'b1;
							phase_d              = sfcs_pkg::PH_WREN;
						end
					end else begin
						res.error = 1'b1;
					end
				end
				sfcs_pkg::FN_HOST: begin
					if (phase_q == sfcs_pkg::PH_HOST) begin
						res.spi_valid        = 1'b1;
						res.spi_byte         = hb_s1;
						res.cs_release_after = chunk_end;
						phase_d              = sfcs_pkg::PH_PDATA;
					end else begin
						res.error = 1'b1;
					end
				end
				sfcs_pkg::FN_RX: begin
					unique case (phase_q)
						sfcs_pkg::PH_WREN: begin
							res.spi_valid = 1'b1;
							if (op_q == sfcs_pkg::FN_PROG) begin
								res.spi_byte = sfcs_pkg::OP_PROGRAM;
							end else if (op_q == sfcs_pkg::FN_SE) begin
								res.spi_byte = sfcs_pkg::OP_SE;
							end else begin
								res.spi_byte         = sfcs_pkg::OP_BE;
								res.cs_release_after = 1'b1;
							end
							phase_d = sfcs_pkg::PH_CMD;
						end
						sfcs_pkg::PH_CMD: begin
							res.spi_valid = 1'b1;
							if (op_q == sfcs_pkg::FN_BE) begin
								res.spi_byte = sfcs_pkg::OP_RDSR;
								phase_d      = sfcs_pkg::PH_RDSR;
							end else if (op_q == sfcs_pkg::FN_ID) begin
								idx_d        = '0;
								res.spi_byte = sfcs_pkg::DUMMY;
								phase_d      = sfcs_pkg::PH_ID;
							end else begin
								idx_d        = '0;
								res.spi_byte = addr_q[23:16];
								phase_d      = sfcs_pkg::PH_ADDR;
							end
						end
						sfcs_pkg::PH_ADDR: begin
							if (idx_q < 2'd2) begin
								idx_d         = idx_q + 2'd1;
								res.spi_valid = 1'b1;
								res.spi_byte  = (idx_q == 2'd0) ? addr_q[15:8] : addr_q[7:0];
								res.cs_release_after = (idx_q == 2'd1) &&
									(op_q == sfcs_pkg::FN_SE ||
									(op_q == sfcs_pkg::FN_READ && left_q == 16'd0));
							end else if (op_q == sfcs_pkg::FN_READ) begin
								if (left_q == 16'd0) begin
									res.done_res = 1'b1;
									phase_d      = sfcs_pkg::PH_IDLE;
								end else begin
									res.spi_valid        = 1'b1;
									res.spi_byte         = sfcs_pkg::DUMMY;
									res.cs_release_after = (left_q == 16'd1);
									phase_d              = sfcs_pkg::PH_RDATA;
								end
							end else if (op_q == sfcs_pkg::FN_PROG) begin
								res.want_data = 1'b1;
								phase_d       = sfcs_pkg::PH_HOST;
							end else begin
								res.spi_valid = 1'b1;
								res.spi_byte  = sfcs_pkg::OP_RDSR;
								phase_d       = sfcs_pkg::PH_RDSR;
							end
						end
						sfcs_pkg::PH_RDATA: begin
							res.read_valid = 1'b1;
							res.read_byte  = rx_s1;
							left_d         = left_dec;
							if (left_dec == 16'd0) begin
								res.done_res = 1'b1;
								phase_d      = sfcs_pkg::PH_IDLE;
							end else begin
								res.spi_valid        = 1'b1;
								res.spi_byte         = sfcs_pkg::DUMMY;
								res.cs_release_after = (left_dec == 16'd1);
							end
						end
						sfcs_pkg::PH_PDATA: begin
							left_d = left_dec;
							addr_d = addr_q + 24'd1;
							if (addr_q == sfcs_pkg::ADDR_TOP || rem_q == PW'(PAGE_BYTES - 1)) begin
								rem_d = '0;
							end else begin
								rem_d = rem_q + PW'(1);
							end
							if (chunk_end) begin
								res.spi_valid = 1'b1;
								res.spi_byte  = sfcs_pkg::OP_RDSR;
								phase_d       = sfcs_pkg::PH_RDSR;
							end else begin
								res.want_data = 1'b1;
								phase_d       = sfcs_pkg::PH_HOST;
							end
						end
						sfcs_pkg::PH_RDSR: begin
							res.spi_valid = 1'b1;
							res.spi_byte  = sfcs_pkg::DUMMY;
							phase_d       = sfcs_pkg::PH_POLL;
						end
						sfcs_pkg::PH_POLL: begin
							if (rx_s1[sfcs_pkg::WIP_BIT]) begin
								res.spi_valid = 1'b1;
								res.spi_byte  = sfcs_pkg::DUMMY;
							end else begin
								res.cs_release_before = 1'b1;
								if (op_q == sfcs_pkg::FN_PROG && left_q != 16'd0) begin
									// next page
									res.spi_valid        = 1'b1;
									res.spi_byte         = sfcs_pkg::OP_WREN;
									res.cs_release_after = 1'b1;
									phase_d              = sfcs_pkg::PH_WREN;
								end else begin
									res.done_res = 1'b1;
									phase_d      = sfcs_pkg::PH_IDLE;
								end
							end
						end
						sfcs_pkg::PH_ID: begin
							if (idx_q < 2'd2) begin
								id_d                 = {id_q[7:0], rx_s1};
								idx_d                = idx_q + 2'd1;
								res.spi_valid        = 1'b1;
								res.spi_byte         = sfcs_pkg::DUMMY;
								res.cs_release_after = (idx_q == 2'd1);
							end else begin
								res.id_valid = 1'b1;
								res.id_value = {id_q, rx_s1};
								res.done_res = 1'b1;
								phase_d      = sfcs_pkg::PH_IDLE;
							end
						end
						default: begin
							// idle or waiting for host data
							res.error = 1'b1;
						end
					endcase
				end
				default: begin
					res.error = 1'b1;
				end
			endcase
		end
	end

	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |=> valid_s1 && $stable(func_s1) && $stable(rx_s1))
		else $error("input register changed while stalled");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !m_tready |=> out_valid_q && $stable(out_q))
		else $error("result word changed while stalled");

	a_state_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!advance && !mod_valid |=> $stable(phase_q) && $stable(left_q) && $stable(rem_q))
		else $error("sequencer state moved without a word");

	a_rem_range: assert property (@(posedge clk) disable iff (!arst_n)
		rem_q <= PW'(PAGE_BYTES - 1))
		else $error("page offset out of range");

	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		idx_q != 2'd3)
		else $error("byte index overflow");

endmodule
